// ----- hdl/atsp_pkg.sv -----
// Shared types, constants and tables for the accelerometer tilt to servo PWM block.
`default_nettype none
package atsp_pkg;

	localparam int CORDIC_STAGES   = 16;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int CORDIC_N        = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

	localparam int XY_GUARD   = 12;
	localparam int ACC_FRAC   = 20;
	localparam int DW         = 32;
	localparam int IDX_W      = 5;

	localparam int SUMSQ_W    = 32;
	localparam int ROOT_W     = 28;
	localparam int REM_W      = 30;
	localparam int SQRT_STEPS = ROOT_W;

	localparam int ANG_W       = 24;
	localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int LIM_ROLL    = 180 << ANGLE_FRAC_BITS;
	localparam int LIM_PITCH   = 90 << ANGLE_FRAC_BITS;
	localparam int DEN         = 180 << ANGLE_FRAC_BITS;
	localparam int DIV_SHIFT   = ANGLE_FRAC_BITS + 2;
	localparam int NUM_W       = 40;
	localparam int SPAN_W      = 13;
	localparam int N_W         = 18;
	localparam int N_SAT       = 4096 * 45;
	localparam int RECIP_W     = 27;
	localparam int RECIP_M     = 95443718;
	localparam int RECIP_SHIFT = 32;
	localparam int PROD_W      = N_W + RECIP_W;

	localparam logic [11:0] PWM_MAX = 12'hFFF;

	typedef enum logic [1:0] {
		REG_SERVO_MIN   = 2'd0,
		REG_SERVO_MAX   = 2'd1,
		REG_ROLL_NEUT   = 2'd2,
		REG_PITCH_NEUT  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [11:0] cnt_lo;
		logic [11:0] cnt_hi;
		logic [7:0]  roll_mid;
		logic [7:0]  pitch_mid;
	} cfg_t;

	typedef struct packed {
		logic [SUMSQ_W-1:0]  s;
		logic [REM_W-1:0]    rem;
		logic [ROOT_W-1:0]   root;
		logic signed [15:0]  ax;
		logic signed [15:0]  ay;
		logic signed [15:0]  az;
	} sq_t;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
		logic                 zero;
	} lane_t;

	typedef struct packed {
		lane_t roll;
		lane_t pitch;
	} cd_t;

	// atan(2^-i) in 2^-20 degree
	function automatic logic signed [DW-1:0] atan_deg(input logic [IDX_W-1:0] i);
		logic signed [DW-1:0] r;
		unique case (i)
			5'd0:  r = 32'sd47185920;
			5'd1:  r = 32'sd27855475;
			5'd2:  r = 32'sd14718068;
			5'd3:  r = 32'sd7471121;
			5'd4:  r = 32'sd3750058;
			5'd5:  r = 32'sd1876857;
			5'd6:  r = 32'sd938658;
			5'd7:  r = 32'sd469357;
			5'd8:  r = 32'sd234682;
			5'd9:  r = 32'sd117342;
			5'd10: r = 32'sd58671;
			5'd11: r = 32'sd29335;
			5'd12: r = 32'sd14668;
			5'd13: r = 32'sd7334;
			5'd14: r = 32'sd3667;
			5'd15: r = 32'sd1833;
			5'd16: r = 32'sd917;
			5'd17: r = 32'sd458;
			5'd18: r = 32'sd229;
			5'd19: r = 32'sd115;
			5'd20: r = 32'sd57;
			5'd21: r = 32'sd29;
			5'd22: r = 32'sd14;
			5'd23: r = 32'sd7;
			default: r = '0;
		endcase
		return r;
	endfunction

	// quadrant fold for abscissa below zero
	function automatic lane_t prerotate(input logic signed [DW-1:0] y,
			input logic signed [DW-1:0] x);
		lane_t l;
		l.zero = (x == '0) && (y == '0);
		l.x = x;
		l.y = y;
		l.z = '0;
		if (x[DW-1]) begin
			if (!y[DW-1]) begin
				l.x = y;
				l.y = -x;
				l.z = DW'(90 << ACC_FRAC);
			end else begin
				l.x = -y;
				l.y = x;
				l.z = -DW'(90 << ACC_FRAC);
			end
		end
		return l;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/accel_tilt_to_servo_pwm.sv -----
// Top level: accelerometer sample to roll/pitch angles and servo PWM counts.
//
//  channel | signals                                   | dir | notes
//  --------+-------------------------------------------+-----+-------------------------
//  in      | in_valid in_ready acc_x acc_y acc_z       | in  | one transaction per sample
//  out     | out_valid out_ready roll_angle pitch_angle| out | one transaction per sample
//          | roll_count pitch_count                    |     |
//  cfg     | cfg_we cfg_index cfg_data                 | in  | write only, no wait
//
// One sample per cycle while the pipeline is not held; stages: capture, square sum, 28 root cells,
// fold, 16 CORDIC cells, 4 mapping stages.
// The pipeline advances as one; it holds when the output register is full and
// out_ready is low, and in_ready follows.
// Reset clears valid bits and loads the servo registers with their defaults.
`default_nettype none
module accel_tilt_to_servo_pwm (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic signed [15:0] acc_x,
	input  wire logic signed [15:0] acc_y,
	input  wire logic signed [15:0] acc_z,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic [11:0]      roll_count,
	output logic [11:0]      pitch_count
);

	localparam int NS = atsp_pkg::SQRT_STEPS;
	localparam int NC = atsp_pkg::CORDIC_N;

	atsp_pkg::cfg_t cfg_q;
	logic           en;

	logic                v_s1;
	logic signed [15:0]  ax_s1, ay_s1, az_s1;

	logic                sq_v [NS+1];
	atsp_pkg::sq_t       sq_d [NS+1];

	logic                cd_v [NC+1];
	atsp_pkg::cd_t       cd_d [NC+1];

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cnt_lo    <= 12'd120;
			cfg_q.cnt_hi    <= 12'd720;
			cfg_q.roll_mid  <= 8'd90;
			cfg_q.pitch_mid <= 8'd90;
		end else if (cfg_we) begin
			unique case (atsp_pkg::cfg_reg_t'(cfg_index))
				atsp_pkg::REG_SERVO_MIN:  cfg_q.cnt_lo    <= cfg_data;
				atsp_pkg::REG_SERVO_MAX:  cfg_q.cnt_hi    <= cfg_data;
				atsp_pkg::REG_ROLL_NEUT:  cfg_q.roll_mid  <= cfg_data[7:0];
				atsp_pkg::REG_PITCH_NEUT: cfg_q.pitch_mid <= cfg_data[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			sq_v[0]  <= 1'b0;
			cd_v[0]  <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			sq_v[0]  <= v_s1;
			cd_v[0]  <= sq_v[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= acc_x;
			ay_s1 <= acc_y;
			az_s1 <= acc_z;
		end
	end

	// sum of squares seeds the root chain
	always_ff @(posedge clk) begin
		logic signed [31:0] py;
		logic signed [31:0] pz;
		if (en) begin
			py = ay_s1 * ay_s1;
			pz = az_s1 * az_s1;
			sq_d[0].s    <= $unsigned(py) + $unsigned(pz);
			sq_d[0].rem  <= '0;
			sq_d[0].root <= '0;
			sq_d[0].ax   <= ax_s1;
			sq_d[0].ay   <= ay_s1;
			sq_d[0].az   <= az_s1;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_sqrt
		atsp_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sq_v[i]),
			.in_data   (sq_d[i]),
			.out_valid (sq_v[i+1]),
			.out_data  (sq_d[i+1])
		);
	end

	// scale and fold into the right half plane
	always_ff @(posedge clk) begin
		logic signed [atsp_pkg::DW-1:0] ry, rx, py, px;
		if (en) begin
			ry = atsp_pkg::DW'(sq_d[NS].ay) <<< atsp_pkg::XY_GUARD;
			rx = atsp_pkg::DW'(sq_d[NS].az) <<< atsp_pkg::XY_GUARD;
			py = (-atsp_pkg::DW'(sq_d[NS].ax)) <<< atsp_pkg::XY_GUARD;
			px = $signed(atsp_pkg::DW'(sq_d[NS].root));
			cd_d[0].roll  <= atsp_pkg::prerotate(ry, rx);
			cd_d[0].pitch <= atsp_pkg::prerotate(py, px);
		end
	end

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		atsp_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.idx       (atsp_pkg::IDX_W'(i)),
			.in_valid  (cd_v[i]),
			.in_data   (cd_d[i]),
			.out_valid (cd_v[i+1]),
			.out_data  (cd_d[i+1])
		);
	end

	atsp_pwm u_pwm (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.cfg         (cfg_q),
		.in_valid    (cd_v[NC]),
		.in_data     (cd_d[NC]),
		.out_valid   (out_valid),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.roll_count  (roll_count),
		.pitch_count (pitch_count)
	);

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_angle <= 16'sd23040) && (roll_angle >= -16'sd23040))
		else $error("roll angle out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_angle <= 15'sd11520) && (pitch_angle >= -15'sd11520))
		else $error("pitch angle out of range");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(cd_d[NC]) && out_valid)
		else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// ----- hdl/atsp_sqrt_cell.sv -----
// One digit step of the pipelined integer square root (two radicand bits per cell).
`default_nettype none
module atsp_sqrt_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire atsp_pkg::sq_t in_data,
	output logic               out_valid,
	output atsp_pkg::sq_t      out_data
);

	logic [atsp_pkg::REM_W+1:0] rem2;
	logic [atsp_pkg::REM_W+1:0] trial;
	atsp_pkg::sq_t              nxt;

	always_comb begin
		rem2  = {in_data.rem, in_data.s[atsp_pkg::SUMSQ_W-1 -: 2]};
		trial = {2'b00, in_data.root, 2'b01};
		nxt   = in_data;
		nxt.s = {in_data.s[atsp_pkg::SUMSQ_W-3:0], 2'b00};
		if (rem2 >= trial) begin
			nxt.rem  = atsp_pkg::REM_W'(rem2 - trial);
			nxt.root = {in_data.root[atsp_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = rem2[atsp_pkg::REM_W-1:0];
			nxt.root = {in_data.root[atsp_pkg::ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/atsp_cordic_cell.sv -----
// One CORDIC vectoring iteration for the roll and pitch lanes.
`default_nettype none
module atsp_cordic_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic [atsp_pkg::IDX_W-1:0] idx,
	input  wire logic                       in_valid,
	input  wire atsp_pkg::cd_t              in_data,
	output logic                            out_valid,
	output atsp_pkg::cd_t                   out_data
);

	function automatic atsp_pkg::lane_t rotate(input atsp_pkg::lane_t l,
			input logic [atsp_pkg::IDX_W-1:0] i);
		atsp_pkg::lane_t      r;
		logic signed [atsp_pkg::DW-1:0] dx;
		logic signed [atsp_pkg::DW-1:0] dy;
		logic signed [atsp_pkg::DW-1:0] t;
		dx = l.y >>> i;
		dy = l.x >>> i;
		t  = atsp_pkg::atan_deg(i);
		r  = l;
		if (!l.y[atsp_pkg::DW-1]) begin
			r.x = l.x + dx;
			r.y = l.y - dy;
			r.z = l.z + t;
		end else begin
			r.x = l.x - dx;
			r.y = l.y + dy;
			r.z = l.z - t;
		end
		return r;
	endfunction

	atsp_pkg::cd_t nxt;

	always_comb begin
		nxt.roll  = rotate(in_data.roll, idx);
		nxt.pitch = rotate(in_data.pitch, idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/atsp_pwm.sv -----
// Angle rounding and clamping, servo count mapping, output register.
`default_nettype none
module atsp_pwm (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire atsp_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	input  wire atsp_pkg::cd_t in_data,
	output logic               out_valid,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic [11:0]        roll_count,
	output logic [11:0]        pitch_count
);

	localparam int AW = atsp_pkg::ANG_W;

	logic v_s1, v_s2, v_s3;
	logic signed [AW-1:0] ang_s1 [2];
	logic signed [AW-1:0] ang_s2 [2];
	logic signed [AW-1:0] ang_s3 [2];
	logic signed [atsp_pkg::NUM_W-1:0] num_s2 [2];
	logic [atsp_pkg::PROD_W-1:0] prod_s3 [2];
	logic neg_s3 [2];
	logic over_s3 [2];

	logic signed [AW-1:0] ang_d [2];
	logic signed [atsp_pkg::NUM_W-1:0] num_d [2];
	logic [atsp_pkg::PROD_W-1:0] prod_d [2];
	logic neg_d [2];
	logic over_d [2];
	logic [11:0] pwm_d [2];

	// round half away from zero, then clamp
	always_comb begin
		logic signed [atsp_pkg::DW-1:0] z;
		logic [atsp_pkg::DW-1:0] zabs;
		logic [atsp_pkg::DW:0]   rsum;
		logic signed [AW-1:0]    r;
		logic signed [AW-1:0]    lim;
		for (int k = 0; k < 2; k++) begin
			if (k == 0) begin
				z   = in_data.roll.zero ? '0 : in_data.roll.z;
				lim = AW'(atsp_pkg::LIM_ROLL);
			end else begin
				z   = in_data.pitch.zero ? '0 : in_data.pitch.z;
				lim = AW'(atsp_pkg::LIM_PITCH);
			end
			zabs = z[atsp_pkg::DW-1] ? atsp_pkg::DW'(-z) : atsp_pkg::DW'(z);
			rsum = {1'b0, zabs} + (atsp_pkg::DW+1)'(1 << (atsp_pkg::ROUND_SHIFT - 1));
			r    = AW'(rsum >> atsp_pkg::ROUND_SHIFT);
			if (z[atsp_pkg::DW-1]) begin
				r = -r;
			end
			if (r > lim) begin
				r = lim;
			end else if (r < -lim) begin
				r = -lim;
			end
			ang_d[k] = r;
		end
	end

	// num = min*D + (neutral*2^F - angle)*span
	always_comb begin
		logic signed [AW:0]                      diff;
		logic signed [atsp_pkg::SPAN_W-1:0]      sp;
		logic signed [AW+atsp_pkg::SPAN_W:0]     pr;
		logic [atsp_pkg::NUM_W-1:0]              mnd;
		logic [7:0]                              neu;
		sp  = $signed({1'b0, cfg.cnt_hi}) - $signed({1'b0, cfg.cnt_lo});
		mnd = atsp_pkg::NUM_W'(cfg.cnt_lo) * atsp_pkg::NUM_W'(atsp_pkg::DEN);
		for (int k = 0; k < 2; k++) begin
			neu = (k == 0) ? cfg.roll_mid : cfg.pitch_mid;
			diff = $signed({1'b0, (AW)'(neu) << atsp_pkg::ANGLE_FRAC_BITS})
				- (AW+1)'(ang_s1[k]);
			pr = diff * sp;
			num_d[k] = atsp_pkg::NUM_W'(pr) + $signed(mnd);
		end
	end

	// divide by D: shift by its power of two, then reciprocal of 45
	always_comb begin
		logic signed [atsp_pkg::NUM_W-1:0] n;
		logic [atsp_pkg::N_W-1:0]          ns;
		for (int k = 0; k < 2; k++) begin
			n = num_s2[k] >>> atsp_pkg::DIV_SHIFT;
			neg_d[k]  = num_s2[k][atsp_pkg::NUM_W-1];
			over_d[k] = !neg_d[k] && (n >= atsp_pkg::NUM_W'(atsp_pkg::N_SAT));
			ns = (neg_d[k] || over_d[k]) ? '0 : n[atsp_pkg::N_W-1:0];
			prod_d[k] = atsp_pkg::PROD_W'(ns) * atsp_pkg::PROD_W'(atsp_pkg::RECIP_M);
		end
	end

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			priority if (neg_s3[k]) begin
				pwm_d[k] = '0;
			end else if (over_s3[k]) begin
				pwm_d[k] = atsp_pkg::PWM_MAX;
			end else begin
				pwm_d[k] = prod_s3[k][atsp_pkg::RECIP_SHIFT +: 12];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				ang_s1[k]  <= ang_d[k];
				ang_s2[k]  <= ang_s1[k];
				num_s2[k]  <= num_d[k];
				ang_s3[k]  <= ang_s2[k];
				prod_s3[k] <= prod_d[k];
				neg_s3[k]  <= neg_d[k];
				over_s3[k] <= over_d[k];
			end
			roll_angle  <= ang_s3[0][15:0];
			pitch_angle <= ang_s3[1][14:0];
			roll_count  <= pwm_d[0];
			pitch_count <= pwm_d[1];
		end
	end

endmodule
`default_nettype wire

// ----- test/accel_tilt_to_servo_pwm_tb.sv -----
// Self-checking testbench for the accelerometer tilt to servo PWM pipeline.
`default_nettype none
module accel_tilt_to_servo_pwm_tb;

	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic [11:0]        roll_count;
		logic [11:0]        pitch_count;
	} tilt_result_t;

	class tilt_scoreboard;
		tilt_result_t pending_q[$];
		longint cnt_lo, cnt_hi, roll_neut, pitch_neut;
		int errors;
		int checked;
		longint atan_tab[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
			938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
			917, 458, 229, 115, 57, 29, 14, 7};

		function void reset_regs();
			cnt_lo = 120;
			cnt_hi = 720;
			roll_neut = 90;
			pitch_neut = 90;
		endfunction

		function void set_reg(atsp_pkg::cfg_reg_t idx, logic [11:0] val);
			unique case (idx)
				atsp_pkg::REG_SERVO_MIN:  cnt_lo = val;
				atsp_pkg::REG_SERVO_MAX:  cnt_hi = val;
				atsp_pkg::REG_ROLL_NEUT:  roll_neut = val[7:0];
				atsp_pkg::REG_PITCH_NEUT: pitch_neut = val[7:0];
			endcase
		endfunction

		function longint root64(longint v);
			longint r, b;
			r = 0;
			b = 64'sd1 <<< 62;
			while (b > v) b = b >>> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >>> 1) + b;
				end else begin
					r = r >>> 1;
				end
				b = b >>> 2;
			end
			return r;
		endfunction

		// vectoring atan2 in 2^-20 degree
		function longint vector_angle(longint y, longint x);
			longint z, t, dx, dy;
			z = 0;
			if (x == 0 && y == 0) return 0;
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y;
					y = -t;
					z = 64'sd90 <<< atsp_pkg::ACC_FRAC;
				end else begin
					x = -y;
					y = t;
					z = -(64'sd90 <<< atsp_pkg::ACC_FRAC);
				end
			end
			for (int i = 0; i < atsp_pkg::CORDIC_N; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x = x + dx;
					y = y - dy;
					z = z + atan_tab[i];
				end else begin
					x = x - dx;
					y = y + dy;
					z = z - atan_tab[i];
				end
			end
			return z;
		endfunction

		function longint round_angle(longint z, longint lim_deg);
			longint s, mag, r, lim;
			s = atsp_pkg::ACC_FRAC - atsp_pkg::ANGLE_FRAC_BITS;
			mag = (z < 0) ? -z : z;
			r = (mag + (64'sd1 <<< (s - 1))) >>> s;
			lim = lim_deg <<< atsp_pkg::ANGLE_FRAC_BITS;
			if (z < 0) r = -r;
			if (r > lim) r = lim;
			if (r < -lim) r = -lim;
			return r;
		endfunction

		function logic [11:0] servo_count(longint angle, longint neutral);
			longint d, span, num, c;
			d = 64'sd180 <<< atsp_pkg::ANGLE_FRAC_BITS;
			span = cnt_hi - cnt_lo;
			num = cnt_lo * d + ((neutral <<< atsp_pkg::ANGLE_FRAC_BITS) - angle) * span;
			c = num / d;
			if (c < 0) c = 0;
			if (c > 4095) c = 4095;
			return c[11:0];
		endfunction

		function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
				logic signed [15:0] az);
			longint x, y, z, mag, roll, pitch;
			tilt_result_t e;
			x = ax;
			y = ay;
			z = az;
			mag = root64((y * y + z * z) <<< (2 * atsp_pkg::XY_GUARD));
			roll = round_angle(vector_angle(y <<< atsp_pkg::XY_GUARD,
				z <<< atsp_pkg::XY_GUARD), 180);
			pitch = round_angle(vector_angle((-x) <<< atsp_pkg::XY_GUARD, mag), 90);
			e.roll = roll[15:0];
			e.pitch = pitch[14:0];
			e.roll_count = servo_count(roll, roll_neut);
			e.pitch_count = servo_count(pitch, pitch_neut);
			pending_q.push_back(e);
		endfunction

		function void check_result(tilt_result_t a);
			tilt_result_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected output transaction");
				errors++;
				return;
			end
			e = pending_q.pop_front();
			checked++;
			if (a.roll !== e.roll) begin
				$error("roll_angle expected %0d got %0d", e.roll, a.roll);
				errors++;
			end
			if (a.pitch !== e.pitch) begin
				$error("pitch_angle expected %0d got %0d", e.pitch, a.pitch);
				errors++;
			end
			if (a.roll_count !== e.roll_count) begin
				$error("roll_count expected %0d got %0d", e.roll_count, a.roll_count);
				errors++;
			end
			if (a.pitch_count !== e.pitch_count) begin
				$error("pitch_count expected %0d got %0d", e.pitch_count, a.pitch_count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [11:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] acc_x = '0, acc_y = '0, acc_z = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic [11:0] roll_count, pitch_count;

	tilt_scoreboard sb = new();
	bit quiet = 0;
	int hold_cycles = 0;
	int cycle_cnt = 0;
	int sent = 0;

	accel_tilt_to_servo_pwm DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		tilt_result_t a;
		cycle_cnt++;
		if (cycle_cnt > 300000) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (arst_n && in_valid && in_ready) sb.note_sample(acc_x, acc_y, acc_z);
		if (arst_n && out_valid && out_ready) begin
			a.roll = roll_angle;
			a.pitch = pitch_angle;
			a.roll_count = roll_count;
			a.pitch_count = pitch_count;
			sb.check_result(a);
		end
	end

	// receiver back-pressure
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 0;
				hold_cycles--;
			end else if (burst > 0) begin
				out_ready = 0;
				burst--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 12) - 1;
				out_ready = 0;
			end else begin
				out_ready = arst_n;
			end
		end
	end

	task automatic write_reg(atsp_pkg::cfg_reg_t idx, logic [11:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		sb.set_reg(idx, val);
	endtask

	task automatic drain();
		in_valid = 0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		acc_x = x;
		acc_y = y;
		acc_z = z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	function automatic logic signed [15:0] rand_axis();
		int m;
		m = $urandom_range(0, 9);
		if (m < 4) return 16'($urandom());
		if (m < 7) return 16'($urandom_range(0, 34000) - 17000);
		if (m == 7) return 16'sd0;
		if (m == 8) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		return 16'($urandom_range(0, 8) - 4);
	endfunction

	task automatic random_samples(int n);
		repeat (n) send_sample(rand_axis(), rand_axis(), rand_axis());
	endtask

	initial begin
		sb.reset_regs();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed corners at reset settings
		send_sample(0, 0, 0);
		send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000);
		send_sample(0, 0, -100);
		send_sample(0, 0, 16'sh8000);
		send_sample(0, 100, -100);
		send_sample(0, -100, -100);
		send_sample(0, 100, 0);
		send_sample(0, -100, 0);
		send_sample(16'sh8000, 0, 0);
		send_sample(16'sh7FFF, 0, 0);
		send_sample(100, 0, 16384);
		send_sample(-100, 16384, 0);
		send_sample(-1, -1, -1);
		send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
		send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);
		random_samples(40);

		// stall the output long enough to fill the pipeline
		hold_cycles = 200;
		random_samples(80);
		drain();

		write_reg(atsp_pkg::REG_SERVO_MIN, 12'd0);
		write_reg(atsp_pkg::REG_SERVO_MAX, 12'hFFF);
		write_reg(atsp_pkg::REG_ROLL_NEUT, 12'd0);
		write_reg(atsp_pkg::REG_PITCH_NEUT, 12'd180);
		random_samples(70);
		drain();

		// reversed span, neutral beyond range
		write_reg(atsp_pkg::REG_SERVO_MIN, 12'hFFF);
		write_reg(atsp_pkg::REG_SERVO_MAX, 12'd0);
		write_reg(atsp_pkg::REG_ROLL_NEUT, 12'd180);
		write_reg(atsp_pkg::REG_PITCH_NEUT, 12'hFFF);
		send_sample(0, 0, 0);
		send_sample(0, 0, -5);
		random_samples(70);
		drain();

		write_reg(atsp_pkg::REG_SERVO_MIN, 12'($urandom_range(0, 4095)));
		write_reg(atsp_pkg::REG_SERVO_MAX, 12'($urandom_range(0, 4095)));
		write_reg(atsp_pkg::REG_ROLL_NEUT, 12'($urandom_range(0, 180)));
		write_reg(atsp_pkg::REG_PITCH_NEUT, 12'($urandom_range(0, 255)));
		random_samples(80);
		drain();

		quiet = 1;
		write_reg(atsp_pkg::REG_SERVO_MIN, 12'd120);
		write_reg(atsp_pkg::REG_SERVO_MAX, 12'd720);
		write_reg(atsp_pkg::REG_ROLL_NEUT, 12'd90);
		write_reg(atsp_pkg::REG_PITCH_NEUT, 12'd90);
		random_samples(90);
		drain();

		$display("Covered %0d samples, %0d results checked, over five servo settings",
			sent, sb.checked);
		$display("including reversed span, out-of-range neutral and a long output stall.");
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/atsp_pkg.sv
hdl/atsp_sqrt_cell.sv
hdl/atsp_cordic_cell.sv
hdl/atsp_pwm.sv
hdl/accel_tilt_to_servo_pwm.sv
test/accel_tilt_to_servo_pwm_tb.sv
